### rtl/core/rmpc_pkg.sv
// Package for the RPC method path checker: codes, tracker state type,
// character classes, the identifier grammar step and the reserved name table.
// No dependencies.
package rmpc_pkg;

  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;

  // Length of the reserved name "__default__"; an overlong path never matches it.
  localparam logic [3:0] DEFAULT_NAME_LEN = 4'd11;
  localparam logic [3:0] INDEX_MAX        = 4'd15;

  typedef enum logic [2:0] {
    ERR_EMPTY         = 3'd0,
    ERR_LEADING_SLASH = 3'd1,
    ERR_NO_SLASH      = 3'd2,
    ERR_EMPTY_METHOD  = 3'd3,
    ERR_EXTRA_SLASH   = 3'd4,
    ERR_NO_DOT        = 3'd5,
    ERR_FORMAT        = 3'd6
  } err_code_t;

  typedef enum logic [2:0] {
    GS_ID0_START = 3'd0,
    GS_ID0_BODY  = 3'd1,
    GS_SEG_START = 3'd2,
    GS_SEG_BODY  = 3'd3,
    GS_M_START   = 3'd4,
    GS_M_BODY    = 3'd5,
    GS_FAIL      = 3'd6
  } gram_state_t;

  typedef struct packed {
    logic        default_match;
    logic [3:0]  byte_index;
    logic [1:0]  slash_count;
    logic        dot_before_slash;
    logic        first_was_slash;
    logic        prev_was_slash;
    gram_state_t grammar_state;
  } path_state_t;

  localparam path_state_t PATH_STATE_RESET = '{
    default_match:    1'b1,
    byte_index:       4'd0,
    slash_count:      2'd0,
    dot_before_slash: 1'b0,
    first_was_slash:  1'b0,
    prev_was_slash:   1'b0,
    grammar_state:    GS_ID0_START
  };

  function automatic logic is_id_start(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f};
  endfunction

  function automatic logic is_id_char(input logic [7:0] c);
    return is_id_start(c) || (c inside {[8'h30:8'h39]});
  endfunction

  function automatic gram_state_t grammar_next(input gram_state_t s, input logic [7:0] c);
    gram_state_t n;
    n = GS_FAIL;
    case (s)
      GS_ID0_START: n = is_id_start(c) ? GS_ID0_BODY : GS_FAIL;
      GS_ID0_BODY: begin
        if (is_id_char(c))      n = GS_ID0_BODY;
        else if (c == CHAR_DOT) n = GS_SEG_START;
        else                    n = GS_FAIL;
      end
      GS_SEG_START: n = is_id_start(c) ? GS_SEG_BODY : GS_FAIL;
      GS_SEG_BODY: begin
        if (is_id_char(c))        n = GS_SEG_BODY;
        else if (c == CHAR_DOT)   n = GS_SEG_START;
        else if (c == CHAR_SLASH) n = GS_M_START;
        else                      n = GS_FAIL;
      end
      GS_M_START: n = is_id_start(c) ? GS_M_BODY : GS_FAIL;
      GS_M_BODY:  n = is_id_char(c) ? GS_M_BODY : GS_FAIL;
      default:    n = GS_FAIL;
    endcase
    return n;
  endfunction

  // "__default__" padded with zero bytes
  function automatic logic [7:0] reserved_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h5f;
      4'd1:    b = 8'h5f;
      4'd2:    b = 8'h64;
      4'd3:    b = 8'h65;
      4'd4:    b = 8'h66;
      4'd5:    b = 8'h61;
      4'd6:    b = 8'h75;
      4'd7:    b = 8'h6c;
      4'd8:    b = 8'h74;
      4'd9:    b = 8'h5f;
      4'd10:   b = 8'h5f;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/rmpc_tracker.sv
// Running path state: reserved name match, byte count, slash and dot flags,
// identifier grammar automaton. Depends on rmpc_pkg.
module rmpc_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           char_byte,
  input  logic                 no_char,
  input  logic                 last,
  output rmpc_pkg::path_state_t upd
);

  rmpc_pkg::path_state_t cur;
  logic                  slash;

  always_comb begin
    slash = (char_byte == rmpc_pkg::CHAR_SLASH);
    upd   = cur;
    if (!no_char) begin
      if (cur.byte_index >= rmpc_pkg::DEFAULT_NAME_LEN ||
          rmpc_pkg::reserved_byte(cur.byte_index) != char_byte)
        upd.default_match = 1'b0;
      if (cur.byte_index == 4'd0)
        upd.first_was_slash = slash;
      if (char_byte == rmpc_pkg::CHAR_DOT && cur.slash_count == 2'd0)
        upd.dot_before_slash = 1'b1;
      if (slash && cur.slash_count < 2'd2)
        upd.slash_count = cur.slash_count + 2'd1;
      upd.prev_was_slash = slash;
      upd.grammar_state  = rmpc_pkg::grammar_next(cur.grammar_state, char_byte);
      if (cur.byte_index < rmpc_pkg::INDEX_MAX)
        upd.byte_index = cur.byte_index + 4'd1;
    end
  end

  // the path ends on the last transaction; start over for the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= rmpc_pkg::PATH_STATE_RESET;
    end else if (step) begin
      cur <= last ? rmpc_pkg::PATH_STATE_RESET : upd;
    end
  end

endmodule

### rtl/core/rmpc_verdict.sv
// Final check of a finished path and the result register toward the master side.
// Depends on rmpc_pkg.
module rmpc_verdict (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  rmpc_pkg::path_state_t fin,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [7:0]            m_tdata
);

  logic                valid_res;
  rmpc_pkg::err_code_t err;
  logic                res_valid;
  rmpc_pkg::err_code_t res_err;

  always_comb begin
    valid_res = 1'b0;
    err       = rmpc_pkg::ERR_EMPTY;
    if (fin.default_match && fin.byte_index == rmpc_pkg::DEFAULT_NAME_LEN)
      valid_res = 1'b1;
    else if (fin.byte_index == 4'd0)
      err = rmpc_pkg::ERR_EMPTY;
    else if (fin.first_was_slash)
      err = rmpc_pkg::ERR_LEADING_SLASH;
    else if (fin.slash_count == 2'd0)
      err = rmpc_pkg::ERR_NO_SLASH;
    else if (fin.slash_count == 2'd1 && fin.prev_was_slash)
      err = rmpc_pkg::ERR_EMPTY_METHOD;
    else if (fin.slash_count >= 2'd2)
      err = rmpc_pkg::ERR_EXTRA_SLASH;
    else if (!fin.dot_before_slash)
      err = rmpc_pkg::ERR_NO_DOT;
    else if (fin.grammar_state != rmpc_pkg::GS_M_BODY)
      err = rmpc_pkg::ERR_FORMAT;
    else
      valid_res = 1'b1;
    if (valid_res)
      err = rmpc_pkg::ERR_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_valid <= valid_res;
      res_err   <= err;
    end
  end

  assign m_tdata = {4'd0, res_err, res_valid};

endmodule

### rtl/core/rpc_method_path_checker.sv
// Top level of the RPC method path checker: input register, path tracker,
// verdict and result register. Depends on rmpc_pkg, rmpc_tracker, rmpc_verdict.
//
// Usage: the slave side takes one path byte per transaction (s_tdata), with
// s_tuser set for a transaction that carries no byte (only used to close an
// empty path) and s_tlast on the final transaction of the path. A transaction
// with s_tuser set and s_tlast clear is dropped.
// The master side gives one result per path, on the transaction that carried
// s_tlast: valid flag and error code (0 when valid).
// Throughput: one transaction per cycle on the slave side, set by the single
// input register feeding the tracker state update, while no last byte stalls.
// Result path: a last transaction goes through the input register and then the
// result register, which raises m_tvalid.
// Stall: while a result waits on m_tready, bytes that are not last keep
// flowing; a last byte waits in the input register, and s_tready drops only
// then. s_tready depends combinationally on m_tready.
// Reset: synchronous rst empties the input and result registers and returns
// the path state to the start of a new path.
module rpc_method_path_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_byte
  input  logic       s_tuser,   // [0] no_char
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] valid_res, [3:1] error_code, [7:4] zero
);

  logic                  s1_valid;
  logic [7:0]            s1_char;
  logic                  s1_no_char;
  logic                  s1_last;
  logic                  s1_move;
  rmpc_pkg::path_state_t upd;

  // an item leaves the input register when it makes no result or the
  // result register is free this cycle
  assign s1_move  = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_char    <= s_tdata;
      s1_no_char <= s_tuser;
      s1_last    <= s_tlast;
    end
  end

  rmpc_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_move),
    .char_byte (s1_char),
    .no_char   (s1_no_char),
    .last      (s1_last),
    .upd       (upd)
  );

  rmpc_verdict u_verdict (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_move && s1_last),
    .fin      (upd),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_last |=> m_tvalid)
    else $error("finished path produced no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled while input register empty");

  a_valid_no_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[3:1] == 3'd0 && m_tdata[7:4] == 4'd0)
    else $error("accepted path carries an error code");

endmodule
